### rtl/core/adc_level_moving_average_macros.svh
// assertion macros for the adc level moving average block
`ifndef ADC_LEVEL_MOVING_AVERAGE_MACROS_SVH
`define ADC_LEVEL_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define ALMA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while reset is held
`define ALMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/alma_pkg.sv
// shared constants, widths and control structs of the adc level moving average
package alma_pkg;

    localparam int unsigned WINDOW      = 60;
    localparam int unsigned CODE_W      = 12;
    localparam int unsigned LEVEL_W     = 7;
    localparam int unsigned AVG_W       = 15;
    localparam int unsigned HELD_W      = 6;
    localparam int unsigned FRAC_W      = 8;

    localparam int unsigned LEVEL_MAX   = 100;
    localparam int unsigned CODE_LOW    = 2110;
    localparam int unsigned CODE_HIGH   = 2543;
    localparam int unsigned SCALE_NUM   = 440;
    localparam int unsigned SCALE_OFF   = 928200;

    // floor(x / 1911) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2^18
    localparam int unsigned RECIP_MUL   = 280938;
    localparam int unsigned RECIP_SHIFT = 29;

    localparam int unsigned PROD_W      = 21;
    localparam int unsigned X_W         = 18;
    localparam int unsigned RECIP_W     = 19;

    localparam int unsigned SLOT_W      = $clog2(WINDOW);
    localparam int unsigned FILL_W      = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W       = $clog2(WINDOW * LEVEL_MAX + 1);
    localparam int unsigned DIVD_W      = SUM_W + FRAC_W;
    localparam int unsigned ITER_W      = $clog2(DIVD_W);

    typedef struct packed {
        logic load;
        logic scale;
        logic level;
        logic update;
        logic div_step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_status;

endpackage

### rtl/core/alma_if.sv
// valid/ready channel interfaces for the sample input and the result output
interface alma_in_if
    import alma_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

interface alma_out_if
    import alma_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic [AVG_W-1:0]   average_q8;
    logic [HELD_W-1:0]  samples_held;

    modport source (output valid, output level, output average_q8, output samples_held,
                    input ready);
    modport sink   (input valid, input level, input average_q8, input samples_held,
                    output ready);
endinterface

### rtl/core/alma_datapath.sv
// datapath: code scaling, window memory, running sum, serial divider, result register
module alma_datapath
    import alma_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic [CODE_W-1:0]  i_adc_code,
    output logic [LEVEL_W-1:0] o_level,
    output logic [AVG_W-1:0]   o_average_q8,
    output logic [HELD_W-1:0]  o_samples_held
);

    logic [CODE_W-1:0]        r_code;
    logic                     r_below;
    logic                     r_above;
    logic [X_W-1:0]           r_x;
    logic [LEVEL_W-1:0]       r_level;
    logic [LEVEL_W-1:0]       r_rd_data;
    logic [LEVEL_W-1:0]       r_mem [WINDOW];

    logic [SLOT_W-1:0]        r_slot;
    logic [FILL_W-1:0]        r_fill;
    logic [SUM_W-1:0]         r_sum;

    logic [DIVD_W-1:0]        r_dq;
    logic [FILL_W-1:0]        r_rem;
    logic [FILL_W-1:0]        r_dvs;
    logic [ITER_W-1:0]        r_iter;

    logic [LEVEL_W-1:0]       r_o_level;
    logic [AVG_W-1:0]         r_o_avg;
    logic [HELD_W-1:0]        r_o_held;

    logic [PROD_W-1:0]        scaled;
    logic [X_W+RECIP_W-1:0]   recip_prod;
    logic [LEVEL_W-1:0]       n_level;
    logic                     full;
    logic [SUM_W-1:0]         old_level;
    logic [SUM_W-1:0]         n_sum;
    logic [FILL_W-1:0]        n_fill;
    logic [SLOT_W-1:0]        n_slot;
    logic [FILL_W:0]          trial;
    logic [FILL_W:0]          diff;
    logic                     ge;
    logic [FILL_W-1:0]        n_rem;

    always_comb begin
        scaled     = PROD_W'(r_code) * PROD_W'(SCALE_NUM) - PROD_W'(SCALE_OFF);
        recip_prod = (X_W+RECIP_W)'(r_x) * (X_W+RECIP_W)'(RECIP_MUL);
        if (r_below) begin
            n_level = '0;
        end else if (r_above) begin
            n_level = LEVEL_W'(LEVEL_MAX);
        end else begin
            n_level = recip_prod[RECIP_SHIFT +: LEVEL_W];
        end
    end

    // oldest entry leaves the sum only once the window is full
    always_comb begin
        full      = (r_fill == FILL_W'(WINDOW));
        old_level = full ? SUM_W'(r_rd_data) : '0;
        n_sum     = r_sum - old_level + SUM_W'(r_level);
        n_fill    = full ? r_fill : r_fill + 1'b1;
        n_slot    = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
    end

    // restoring divide, one quotient bit a step
    always_comb begin
        trial = {r_rem, r_dq[DIVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_rd_data <= r_mem[r_slot];
        end
        if (i_cmd.update) begin
            r_mem[r_slot] <= r_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_cmd.update) begin
            r_slot <= n_slot;
            r_fill <= n_fill;
            r_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code <= i_adc_code;
        end
        if (i_cmd.scale) begin
            r_below <= (r_code < CODE_W'(CODE_LOW));
            r_above <= (r_code > CODE_W'(CODE_HIGH));
            r_x     <= scaled[X_W-1:0];
        end
        if (i_cmd.level) begin
            r_level <= n_level;
        end
        if (i_cmd.update) begin
            r_dq   <= {n_sum, FRAC_W'(0)};
            r_dvs  <= n_fill;
            r_rem  <= '0;
            r_iter <= ITER_W'(DIVD_W - 1);
        end else if (i_cmd.div_step) begin
            r_dq   <= {r_dq[DIVD_W-2:0], ge};
            r_rem  <= n_rem;
            r_iter <= r_iter - 1'b1;
        end
        if (i_cmd.publish) begin
            r_o_level <= r_level;
            r_o_avg   <= AVG_W'(r_dq);
            r_o_held  <= HELD_W'(r_dvs);
        end
    end

    assign o_status.div_last = (r_iter == '0);
    assign o_level           = r_o_level;
    assign o_average_q8      = r_o_avg;
    assign o_samples_held    = r_o_held;

endmodule

### rtl/core/alma_ctrl.sv
// controller: sequences one sample through scale, update and divide, owns the handshakes
module alma_ctrl
    import alma_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_LEVEL,
        S_UPDATE,
        S_DIVIDE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scale    = (r_state == S_SCALE);
        o_cmd.level    = (r_state == S_LEVEL);
        o_cmd.update   = (r_state == S_UPDATE);
        o_cmd.div_step = (r_state == S_DIVIDE);
        o_cmd.publish  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid)        n_state = S_SCALE;
            S_SCALE:                         n_state = S_LEVEL;
            S_LEVEL:                         n_state = S_UPDATE;
            S_UPDATE:                        n_state = S_DIVIDE;
            S_DIVIDE: if (i_status.div_last) n_state = S_DONE;
            S_DONE:   if (o_cmd.publish)     n_state = S_IDLE;
            default:                         n_state = S_IDLE;
        endcase

        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/adc_level_moving_average.sv
// top level of the adc level moving average: controller, datapath and checks
//
// usage
// - i_in carries one 12-bit converter code per transfer; o_out returns one result per
//   sample: the 0..100 level, the windowed mean in unsigned q8 and the sample count
// - the mean covers the last 60 levels; while the window fills it covers all seen so far
// - one sample is worked at a time; ready on i_in is high only while the block is idle
// - a sample passes through scale, level and update (scaling and window update), then
//   the restoring divider, one quotient bit per cycle over the 21-bit scaled sum, then
//   done, which loads the output register once it is free, and back to idle, in which
//   the next transfer is taken; a new sample is not taken before the last is through
// - a finished result sits in an output register; the next sample is taken while it
//   waits; a later result is held back until the receiver has taken the earlier one
// - reset (synchronous, active low) empties the window, clears the sum, count and write
//   slot and drops o_out valid; the window memory itself is not cleared
`include "adc_level_moving_average_macros.svh"

module adc_level_moving_average
    import alma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    alma_in_if.sink     i_in,
    alma_out_if.source  o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencing and handshake ownership
    alma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // arithmetic, window memory and result register
    alma_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_adc_code     (i_in.adc_code),
        .o_level        (o_out.level),
        .o_average_q8   (o_out.average_q8),
        .o_samples_held (o_out.samples_held)
    );

    // block stays busy once a sample has been taken
    `ALMA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in.valid && i_in.ready, !i_in.ready, "input taken while a sample is in work")

    // a published result always counts at least one and at most a full window
    `ALMA_ASSERT_IMP(a_held_range, i_clk, i_rst_n, o_out.valid,
        (o_out.samples_held != '0) && (o_out.samples_held <= HELD_W'(WINDOW)),
        "sample count out of range")

    // the mean of levels never exceeds the top level in q8
    `ALMA_ASSERT_IMP(a_avg_range, i_clk, i_rst_n, o_out.valid,
        o_out.average_q8 <= AVG_W'(LEVEL_MAX << FRAC_W), "average above full scale")

    // scaled level stays within 0..100
    `ALMA_ASSERT_IMP(a_level_range, i_clk, i_rst_n, o_out.valid,
        o_out.level <= LEVEL_W'(LEVEL_MAX), "level above full scale")

endmodule
